// ----- design/premultiplied_pixel_compositor_unit_macros.svh -----
// Assertion helpers for the compositor. All checks are clocked on clk and
// are off while rst_n is low.
`ifndef PREMULTIPLIED_PIXEL_COMPOSITOR_UNIT_MACROS_SVH
`define PREMULTIPLIED_PIXEL_COMPOSITOR_UNIT_MACROS_SVH

// Same-cycle implication.
`define PPC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/ppc_pkg.sv -----
`default_nettype none

package ppc_pkg;

  localparam int CH_W           = 8;
  localparam int SUM_W          = 2 * CH_W + 1;
  localparam int DIV_STAGES     = 4;
  localparam int BITS_PER_STAGE = CH_W / DIV_STAGES;
  // Accept edge to first edge that samples out_valid high.
  localparam int LATENCY        = DIV_STAGES + 2;
  // color channels per pixel; alpha follows them
  localparam int NCOL           = 3;

  localparam logic [CH_W-1:0]  FULL      = 8'd255;
  // 255 * 256: any weighted sum at or above this saturates.
  localparam logic [SUM_W-1:0] SAT_LIMIT = 17'd65280;

  typedef enum logic [2:0] {
    MODE_OVER = 3'd0,
    MODE_IN   = 3'd1,
    MODE_OUT  = 3'd2,
    MODE_ATOP = 3'd3,
    MODE_XOR  = 3'd4,
    MODE_DIFF = 3'd5
  } mode_t;

  typedef struct packed {
    logic [CH_W-1:0] blend;
    logic [CH_W-1:0] diff;
  } lane_res_t;

endpackage

`default_nettype wire

// ----- design/premultiplied_pixel_compositor_unit.sv -----
`default_nettype none

`include "premultiplied_pixel_compositor_unit_macros.svh"

// Premultiplied RGBA8 compositor. A pixel pair is taken on every clock where
// start is high and busy is low; busy is high in reset and clears once reset is
// released, so one transaction per clock is sustained. Each result passes an
// input register, 4 divider stages and an output register, and appears as a
// one-cycle out_valid strobe: the receiver cannot stall, and results come out
// in order, one per clock at full rate. Latency is set by the unpremultiply
// divider, 2 quotient bits per stage. The user must write blend_mode through the
// cfg channel only while no transaction is in flight; the block does not enforce it.
module premultiplied_pixel_compositor_unit (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // pixel input
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [ppc_pkg::CH_W-1:0] in_fg_red,
  input  wire logic [ppc_pkg::CH_W-1:0] in_fg_green,
  input  wire logic [ppc_pkg::CH_W-1:0] in_fg_blue,
  input  wire logic [ppc_pkg::CH_W-1:0] in_fg_alpha,
  input  wire logic [ppc_pkg::CH_W-1:0] in_bg_red,
  input  wire logic [ppc_pkg::CH_W-1:0] in_bg_green,
  input  wire logic [ppc_pkg::CH_W-1:0] in_bg_blue,
  input  wire logic [ppc_pkg::CH_W-1:0] in_bg_alpha,
  // result
  output logic                          out_valid,
  output logic      [ppc_pkg::CH_W-1:0] out_red,
  output logic      [ppc_pkg::CH_W-1:0] out_green,
  output logic      [ppc_pkg::CH_W-1:0] out_blue,
  output logic      [ppc_pkg::CH_W-1:0] out_alpha,
  // configuration
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [2:0]               cfg_blend_mode
);
  import ppc_pkg::*;

  logic            busy_r;
  logic [2:0]      blend_mode_r;
  logic            accept;

  // weights chosen at accept time
  logic [CH_W-1:0] k1_nxt;
  logic [CH_W-1:0] k2_nxt;

  // input stage
  logic            vld0_r;
  logic [2:0]      mode0_r;
  logic [CH_W-1:0] fg_r [NCOL+1];
  logic [CH_W-1:0] bg_r [NCOL+1];
  logic [CH_W-1:0] k1_r;
  logic [CH_W-1:0] k2_r;

  // control that travels alongside the lanes
  logic            vld_d_r  [DIV_STAGES];
  logic [2:0]      mode_d_r [DIV_STAGES];

  lane_res_t       lane_res [NCOL];
  logic [CH_W-1:0] alpha_blend;

  // merge and output register
  logic [CH_W-1:0] col_nxt [NCOL];
  logic [CH_W-1:0] alpha_nxt;
  logic            out_valid_r;
  logic [CH_W-1:0] col_r [NCOL];
  logic [CH_W-1:0] alpha_r;

  assign accept    = start && !busy_r;
  assign busy      = busy_r;
  assign cfg_ready = !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b1;
      blend_mode_r <= MODE_OVER;
    end else begin
      busy_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        blend_mode_r <= cfg_blend_mode;
      end
    end
  end

  // Porter-Duff weights; difference and unused codes leave them at zero
  always_comb begin
    case (blend_mode_r)
      MODE_OVER: begin
        k1_nxt = FULL;
        k2_nxt = FULL - in_fg_alpha;
      end
      MODE_IN: begin
        k1_nxt = in_bg_alpha;
        k2_nxt = '0;
      end
      MODE_OUT: begin
        k1_nxt = FULL - in_bg_alpha;
        k2_nxt = '0;
      end
      MODE_ATOP: begin
        k1_nxt = in_bg_alpha;
        k2_nxt = FULL - in_fg_alpha;
      end
      MODE_XOR: begin
        k1_nxt = FULL - in_bg_alpha;
        k2_nxt = FULL - in_fg_alpha;
      end
      default: begin
        k1_nxt = '0;
        k2_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else begin
      vld0_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode0_r <= blend_mode_r;
      fg_r[0] <= in_fg_red;
      fg_r[1] <= in_fg_green;
      fg_r[2] <= in_fg_blue;
      fg_r[3] <= in_fg_alpha;
      bg_r[0] <= in_bg_red;
      bg_r[1] <= in_bg_green;
      bg_r[2] <= in_bg_blue;
      bg_r[3] <= in_bg_alpha;
      k1_r    <= k1_nxt;
      k2_r    <= k2_nxt;
    end
  end

  // valid / mode delay line matching the lane depth
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_d_r[0] <= 1'b0;
    end else begin
      vld_d_r[0] <= vld0_r;
    end
    mode_d_r[0] <= mode0_r;
  end

  for (genvar s = 1; s < DIV_STAGES; s++) begin : g_ctl
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_d_r[s] <= 1'b0;
      end else begin
        vld_d_r[s] <= vld_d_r[s-1];
      end
      mode_d_r[s] <= mode_d_r[s-1];
    end
  end

  // color lanes: red, green, blue
  for (genvar c = 0; c < NCOL; c++) begin : g_lane
    ppc_lane u_lane (
      .clk  (clk),
      .fg_c (fg_r[c]),
      .bg_c (bg_r[c]),
      .fg_a (fg_r[NCOL]),
      .bg_a (bg_r[NCOL]),
      .k1   (k1_r),
      .k2   (k2_r),
      .res  (lane_res[c])
    );
  end

  // alpha only needs the blend path
  ppc_blend u_alpha (
    .clk  (clk),
    .fg_c (fg_r[NCOL]),
    .bg_c (bg_r[NCOL]),
    .k1   (k1_r),
    .k2   (k2_r),
    .res  (alpha_blend)
  );

  // merge: pick blend or difference per mode; unused codes give transparent black
  always_comb begin
    case (mode_d_r[DIV_STAGES-1])
      MODE_OVER, MODE_IN, MODE_OUT, MODE_ATOP, MODE_XOR: begin
        for (int c = 0; c < NCOL; c++) begin
          col_nxt[c] = lane_res[c].blend;
        end
        alpha_nxt = alpha_blend;
      end
      MODE_DIFF: begin
        for (int c = 0; c < NCOL; c++) begin
          col_nxt[c] = lane_res[c].diff;
        end
        alpha_nxt = FULL;
      end
      default: begin
        for (int c = 0; c < NCOL; c++) begin
          col_nxt[c] = '0;
        end
        alpha_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_d_r[DIV_STAGES-1];
    end
    col_r   <= col_nxt;
    alpha_r <= alpha_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_red   = col_r[0];
  assign out_green = col_r[1];
  assign out_blue  = col_r[2];
  assign out_alpha = alpha_r;

  // every transaction yields exactly one strobe, a fixed time later
  `PPC_ASSERT_IMPL(a_latency, 1'b1, out_valid == $past(start && !busy, LATENCY), "result strobe does not match accepted transaction")
  // difference mode always returns opaque alpha
  `PPC_ASSERT_NEXT(a_diff_alpha, vld_d_r[DIV_STAGES-1] && mode_d_r[DIV_STAGES-1] == MODE_DIFF, out_alpha == FULL, "difference mode alpha not 255")
  // unused codes give transparent black
  `PPC_ASSERT_NEXT(a_bad_mode, vld_d_r[DIV_STAGES-1] && mode_d_r[DIV_STAGES-1] > MODE_DIFF, out_red == '0 && out_green == '0 && out_blue == '0 && out_alpha == '0, "unused mode result not zero")

endmodule

`default_nettype wire

// ----- design/ppc_unpremul.sv -----
`default_nettype none

// Pipelined floor(color*255/alpha), 0 for zero alpha, 255 when color > alpha.
module ppc_unpremul (
  input  wire logic                    clk,
  input  wire logic [ppc_pkg::CH_W-1:0] color,
  input  wire logic [ppc_pkg::CH_W-1:0] alpha,
  output logic      [ppc_pkg::CH_W-1:0] quo
);
  import ppc_pkg::*;

  typedef struct packed {
    logic [CH_W-1:0] rem;
    logic [CH_W-1:0] low;
    logic [CH_W-1:0] quo;
    logic [CH_W-1:0] dvs;
    logic            zero;
    logic            sat;
  } div_st_t;

  // Restoring division, BITS_PER_STAGE quotient bits per call.
  function automatic div_st_t div_step(input div_st_t s);
    div_st_t         o;
    logic [CH_W:0]   t;
    o = s;
    for (int j = 0; j < BITS_PER_STAGE; j++) begin
      t     = {o.rem, o.low[CH_W-1]};
      o.low = {o.low[CH_W-2:0], 1'b0};
      if (t >= {1'b0, o.dvs}) begin
        o.rem = CH_W'(t - {1'b0, o.dvs});
        o.quo = {o.quo[CH_W-2:0], 1'b1};
      end else begin
        o.rem = t[CH_W-1:0];
        o.quo = {o.quo[CH_W-2:0], 1'b0};
      end
    end
    return o;
  endfunction

  logic [2*CH_W-1:0] prod;
  div_st_t           init;
  div_st_t           st_r [DIV_STAGES];

  // color*255 as shift and subtract
  assign prod = {color, CH_W'(0)} - {CH_W'(0), color};

  always_comb begin
    init.rem  = prod[2*CH_W-1:CH_W];
    init.low  = prod[CH_W-1:0];
    init.quo  = '0;
    init.dvs  = alpha;
    init.zero = (alpha == '0);
    init.sat  = (color > alpha);
  end

  always_ff @(posedge clk) begin
    st_r[0] <= div_step(init);
  end

  for (genvar s = 1; s < DIV_STAGES; s++) begin : g_stage
    always_ff @(posedge clk) begin
      st_r[s] <= div_step(st_r[s-1]);
    end
  end

  always_comb begin
    if (st_r[DIV_STAGES-1].zero) begin
      quo = '0;
    end else if (st_r[DIV_STAGES-1].sat) begin
      quo = FULL;
    end else begin
      quo = st_r[DIV_STAGES-1].quo;
    end
  end

endmodule

`default_nettype wire

// ----- design/ppc_blend.sv -----
`default_nettype none

// One Porter-Duff channel: sat(floor((f*k1 + b*k2)/255)), DIV_STAGES deep.
module ppc_blend (
  input  wire logic                    clk,
  input  wire logic [ppc_pkg::CH_W-1:0] fg_c,
  input  wire logic [ppc_pkg::CH_W-1:0] bg_c,
  input  wire logic [ppc_pkg::CH_W-1:0] k1,
  input  wire logic [ppc_pkg::CH_W-1:0] k2,
  output logic      [ppc_pkg::CH_W-1:0] res
);
  import ppc_pkg::*;

  // floor(x/255) for x < 255*256 via (y + (y>>8)) >> 8, y = x+1
  function automatic logic [CH_W-1:0] div255_sat(input logic [SUM_W-1:0] x);
    logic [SUM_W-1:0] y;
    logic [SUM_W-1:0] z;
    y = x + SUM_W'(1);
    z = y + (y >> CH_W);
    if (x >= SAT_LIMIT) begin
      return FULL;
    end
    return z[2*CH_W-1:CH_W];
  endfunction

  logic [SUM_W-1:0] sum_r;
  logic [CH_W-1:0]  res_r [DIV_STAGES-1];

  always_ff @(posedge clk) begin
    sum_r    <= SUM_W'(fg_c) * k1 + SUM_W'(bg_c) * k2;
    res_r[0] <= div255_sat(sum_r);
  end

  for (genvar s = 1; s < DIV_STAGES - 1; s++) begin : g_dly
    always_ff @(posedge clk) begin
      res_r[s] <= res_r[s-1];
    end
  end

  assign res = res_r[DIV_STAGES-2];

endmodule

`default_nettype wire

// ----- design/ppc_lane.sv -----
`default_nettype none

// Color lane: blend result and |unpremul(fg) - unpremul(bg)|, both aligned.
module ppc_lane (
  input  wire logic                    clk,
  input  wire logic [ppc_pkg::CH_W-1:0] fg_c,
  input  wire logic [ppc_pkg::CH_W-1:0] bg_c,
  input  wire logic [ppc_pkg::CH_W-1:0] fg_a,
  input  wire logic [ppc_pkg::CH_W-1:0] bg_a,
  input  wire logic [ppc_pkg::CH_W-1:0] k1,
  input  wire logic [ppc_pkg::CH_W-1:0] k2,
  output ppc_pkg::lane_res_t            res
);
  import ppc_pkg::*;

  logic [CH_W-1:0] blend;
  logic [CH_W-1:0] fg_u;
  logic [CH_W-1:0] bg_u;

  ppc_blend u_blend (
    .clk  (clk),
    .fg_c (fg_c),
    .bg_c (bg_c),
    .k1   (k1),
    .k2   (k2),
    .res  (blend)
  );

  ppc_unpremul u_fg_div (
    .clk   (clk),
    .color (fg_c),
    .alpha (fg_a),
    .quo   (fg_u)
  );

  ppc_unpremul u_bg_div (
    .clk   (clk),
    .color (bg_c),
    .alpha (bg_a),
    .quo   (bg_u)
  );

  always_comb begin
    res.blend = blend;
    res.diff  = (fg_u >= bg_u) ? (fg_u - bg_u) : (bg_u - fg_u);
  end

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import ppc_pkg::*;

  // The block decodes 3'd6 and 3'd7 too; both give transparent black.
  localparam logic [2:0] MODE_UNUSED_LO = 3'd6;
  localparam logic [2:0] MODE_UNUSED_HI = 3'd7;

  localparam int RANDOM_PIXELS = 900;
  // Watchdog budget for the whole run, several times over its worst case.
  localparam int CYCLE_LIMIT   = 300000;

  typedef struct packed {
    logic [7:0] fg_red;
    logic [7:0] fg_green;
    logic [7:0] fg_blue;
    logic [7:0] fg_alpha;
    logic [7:0] bg_red;
    logic [7:0] bg_green;
    logic [7:0] bg_blue;
    logic [7:0] bg_alpha;
  } pixel_pair_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

  // What the driver does next: send a pixel pair, write the mode register,
  // or just hold off until the pipeline has drained.
  typedef enum logic [1:0] {JOB_PIXEL, JOB_MODE, JOB_DRAIN} job_kind_t;

  typedef struct {
    job_kind_t   kind;
    logic [2:0]  mode;
    pixel_pair_t px;
    int unsigned gap;  // idle cycles before this job goes out
  } job_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        start = 1'b0;
  logic        busy;
  pixel_pair_t drive_px = '0;
  logic        out_valid;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic [7:0]  out_alpha;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_mode = MODE_OVER;

  job_t        pixel_jobs[$];
  rgba_t       predicted_rgba[$];
  logic [2:0]  shadow_mode;     // our copy of blend_mode
  logic        pix_fire = 1'b0; // last rising edge took a pixel transaction
  logic        cfg_fire = 1'b0; // last rising edge took a mode write
  int unsigned idle_left = 0;
  bit          front_armed = 1'b0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  premultiplied_pixel_compositor_unit u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_fg_red      (drive_px.fg_red),
    .in_fg_green    (drive_px.fg_green),
    .in_fg_blue     (drive_px.fg_blue),
    .in_fg_alpha    (drive_px.fg_alpha),
    .in_bg_red      (drive_px.bg_red),
    .in_bg_green    (drive_px.bg_green),
    .in_bg_blue     (drive_px.bg_blue),
    .in_bg_alpha    (drive_px.bg_alpha),
    .out_valid      (out_valid),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_alpha      (out_alpha),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_blend_mode (cfg_mode)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------

  // Straight (non-premultiplied) color: c*255/a floored, black at zero
  // alpha, clipped at 255 when the color is larger than its alpha.
  function automatic int unsigned straight_color(logic [7:0] c, logic [7:0] a);
    int unsigned q;
    if (a == 8'd0) return 0;
    q = (int'(c) * int'(FULL)) / int'(a);
    return (q > FULL) ? int'(FULL) : q;
  endfunction

  function automatic rgba_t composite_pixel(pixel_pair_t px, logic [2:0] mode);
    logic [7:0]  fg_ch [4];
    logic [7:0]  bg_ch [4];
    logic [7:0]  res_ch [4];
    int unsigned w_fg, w_bg, sum, x, y;
    bit          porter_duff;
    int          i;
    rgba_t       res;
    fg_ch[0] = px.fg_red;
    fg_ch[1] = px.fg_green;
    fg_ch[2] = px.fg_blue;
    fg_ch[3] = px.fg_alpha;
    bg_ch[0] = px.bg_red;
    bg_ch[1] = px.bg_green;
    bg_ch[2] = px.bg_blue;
    bg_ch[3] = px.bg_alpha;
    for (i = 0; i < 4; i++) res_ch[i] = 8'd0;
    w_fg = 0;
    w_bg = 0;
    porter_duff = 1'b1;
    // Weights against fg and bg; alpha goes through the same sum.
    case (mode)
      MODE_OVER: begin w_fg = FULL;               w_bg = FULL - px.fg_alpha; end
      MODE_IN:   begin w_fg = px.bg_alpha;        w_bg = 0;                  end
      MODE_OUT:  begin w_fg = FULL - px.bg_alpha; w_bg = 0;                  end
      MODE_ATOP: begin w_fg = px.bg_alpha;        w_bg = FULL - px.fg_alpha; end
      MODE_XOR:  begin w_fg = FULL - px.bg_alpha; w_bg = FULL - px.fg_alpha; end
      MODE_DIFF: begin
        porter_duff = 1'b0;
        for (i = 0; i < 3; i++) begin
          x = straight_color(fg_ch[i], px.fg_alpha);
          y = straight_color(bg_ch[i], px.bg_alpha);
          res_ch[i] = (x >= y) ? x - y : y - x;
        end
        res_ch[3] = FULL;
      end
      default: porter_duff = 1'b0;  // unused codes: transparent black
    endcase
    if (porter_duff) begin
      for (i = 0; i < 4; i++) begin
        sum = (fg_ch[i] * w_fg + bg_ch[i] * w_bg) / int'(FULL);
        res_ch[i] = (sum > FULL) ? FULL : sum[7:0];
      end
    end
    res.red   = res_ch[0];
    res.green = res_ch[1];
    res.blue  = res_ch[2];
    res.alpha = res_ch[3];
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // Mostly zero, some short, a few long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  function automatic logic [2:0] pick_mode();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 18) return r % 6;
    return (r == 18) ? MODE_UNUSED_LO : MODE_UNUSED_HI;
  endfunction

  // Mostly well-formed premultiplied pixels (color <= alpha); the rest is
  // raw noise or all-extreme fields.
  function automatic pixel_pair_t rand_pixel();
    pixel_pair_t p;
    int unsigned style;
    style = $urandom_range(0, 9);
    p = '0;
    if (style == 0) begin
      p = {$urandom, $urandom};
    end else if (style == 1) begin
      p.fg_red   = $urandom_range(0, 1) ? FULL : 8'd0;
      p.fg_green = $urandom_range(0, 1) ? FULL : 8'd0;
      p.fg_blue  = $urandom_range(0, 1) ? FULL : 8'd0;
      p.fg_alpha = $urandom_range(0, 1) ? FULL : 8'd0;
      p.bg_red   = $urandom_range(0, 1) ? FULL : 8'd0;
      p.bg_green = $urandom_range(0, 1) ? FULL : 8'd0;
      p.bg_blue  = $urandom_range(0, 1) ? FULL : 8'd0;
      p.bg_alpha = $urandom_range(0, 1) ? FULL : 8'd0;
    end else begin
      case ($urandom_range(0, 5))
        0:       p.fg_alpha = 8'd0;
        1:       p.fg_alpha = FULL;
        default: p.fg_alpha = $urandom_range(0, 255);
      endcase
      case ($urandom_range(0, 5))
        0:       p.bg_alpha = 8'd0;
        1:       p.bg_alpha = FULL;
        default: p.bg_alpha = $urandom_range(0, 255);
      endcase
      p.fg_red   = $urandom_range(0, p.fg_alpha);
      p.fg_green = $urandom_range(0, p.fg_alpha);
      p.fg_blue  = $urandom_range(0, p.fg_alpha);
      p.bg_red   = $urandom_range(0, p.bg_alpha);
      p.bg_green = $urandom_range(0, p.bg_alpha);
      p.bg_blue  = $urandom_range(0, p.bg_alpha);
    end
    return p;
  endfunction

  function automatic pixel_pair_t make_pixel(
    logic [7:0] fr, logic [7:0] fgr, logic [7:0] fb, logic [7:0] fa,
    logic [7:0] br, logic [7:0] bgr, logic [7:0] bb, logic [7:0] ba);
    return {fr, fgr, fb, fa, br, bgr, bb, ba};
  endfunction

  task automatic queue_pixel(pixel_pair_t p, int unsigned gap);
    job_t j;
    j.kind = JOB_PIXEL;
    j.mode = MODE_OVER;
    j.px   = p;
    j.gap  = gap;
    pixel_jobs.push_back(j);
  endtask

  task automatic queue_mode(logic [2:0] m);
    job_t j;
    j.kind = JOB_MODE;
    j.mode = m;
    j.px   = '0;
    j.gap  = pick_gap();
    pixel_jobs.push_back(j);
  endtask

  task automatic queue_drain();
    job_t j;
    j.kind = JOB_DRAIN;
    j.mode = MODE_OVER;
    j.px   = '0;
    j.gap  = 0;
    pixel_jobs.push_back(j);
  endtask

  task automatic check_field(string what, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  // ---------------------------------------------------------------------
  // Driver: works at the falling edge. A held start or cfg_valid drops or
  // moves on only after the rising edge flagged it as taken. Mode writes
  // and drain points wait until every predicted result has come back, so
  // the register only changes with nothing in flight.
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    logic start_nx;
    logic cfg_nx;
    start_nx = start && !pix_fire;
    cfg_nx   = cfg_valid && !cfg_fire;
    if (rst_n && !start_nx && !cfg_nx && pixel_jobs.size() != 0) begin
      if (!front_armed) begin
        idle_left   = pixel_jobs[0].gap;
        front_armed = 1'b1;
      end
      if (idle_left != 0) begin
        idle_left--;
      end else begin
        case (pixel_jobs[0].kind)
          JOB_PIXEL: begin
            drive_px    <= pixel_jobs[0].px;
            start_nx    = 1'b1;
            void'(pixel_jobs.pop_front());
            front_armed = 1'b0;
          end
          JOB_MODE: begin
            if (predicted_rgba.size() == 0) begin
              cfg_mode    <= pixel_jobs[0].mode;
              cfg_nx      = 1'b1;
              void'(pixel_jobs.pop_front());
              front_armed = 1'b0;
            end
          end
          default: begin
            if (predicted_rgba.size() == 0) begin
              void'(pixel_jobs.pop_front());
              front_armed = 1'b0;
            end
          end
        endcase
      end
    end
    start     <= start_nx;
    cfg_valid <= cfg_nx;
  end

  // ---------------------------------------------------------------------
  // Monitor: at the rising edge, note handshakes, track the mode register,
  // predict on every accepted pixel pair and check every out_valid strobe
  // against the oldest prediction.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    rgba_t want;
    if (!rst_n) begin
      pix_fire    <= 1'b0;
      cfg_fire    <= 1'b0;
      shadow_mode <= MODE_OVER;
    end else begin
      pix_fire <= start && !busy;
      cfg_fire <= cfg_valid && cfg_ready;
      if (cfg_valid && cfg_ready) shadow_mode <= cfg_mode;
      if (start && !busy) predicted_rgba.push_back(composite_pixel(drive_px, shadow_mode));
      if (out_valid) begin
        if (predicted_rgba.size() == 0) begin
          $display("%0t: result with nothing expected, got %0d %0d %0d %0d",
                   $time, out_red, out_green, out_blue, out_alpha);
          mismatches++;
        end else begin
          want = predicted_rgba.pop_front();
          check_field("out_red", want.red, out_red);
          check_field("out_green", want.green, out_green);
          check_field("out_blue", want.blue, out_blue);
          check_field("out_alpha", want.alpha, out_alpha);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL premultiplied_pixel_compositor_unit");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------
  initial begin
    int unsigned random_sent;
    int unsigned chunk;
    int unsigned chunk_len;
    int unsigned k;
    bit          no_idle;

    // Directed part. The first pixels run at the reset mode (over).
    // Saturation: transparent white fg over opaque white bg sums to 510.
    queue_pixel(make_pixel(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0), 0);
    queue_pixel(make_pixel(FULL, FULL, FULL, FULL, FULL, FULL, FULL, FULL), 0);
    queue_pixel(make_pixel(FULL, FULL, FULL, 8'd0, FULL, FULL, FULL, FULL), 0);
    queue_pixel(make_pixel(8'd60, 8'd10, 8'd128, 8'd128, 8'd200, 8'd0, 8'd90, 8'd220), 1);
    queue_mode(MODE_IN);
    queue_pixel(make_pixel(8'd100, 8'd50, 8'd25, 8'd100, 8'd30, 8'd40, 8'd50, 8'd128), 0);
    queue_pixel(make_pixel(FULL, FULL, FULL, FULL, 8'd0, 8'd0, 8'd0, FULL), 0);
    queue_mode(MODE_OUT);
    queue_pixel(make_pixel(8'd100, 8'd50, 8'd25, 8'd100, 8'd30, 8'd40, 8'd50, 8'd128), 0);
    queue_pixel(make_pixel(FULL, FULL, FULL, FULL, FULL, FULL, FULL, 8'd0), 0);
    queue_mode(MODE_ATOP);
    queue_pixel(make_pixel(8'd80, 8'd20, 8'd70, 8'd90, 8'd200, 8'd150, 8'd10, 8'd210), 0);
    queue_pixel(make_pixel(FULL, FULL, FULL, 8'd0, FULL, FULL, FULL, FULL), 0);
    queue_mode(MODE_XOR);
    queue_pixel(make_pixel(8'd80, 8'd20, 8'd70, 8'd90, 8'd200, 8'd150, 8'd10, 8'd210), 0);
    queue_pixel(make_pixel(FULL, FULL, FULL, 8'd0, FULL, FULL, FULL, 8'd0), 0);
    queue_mode(MODE_DIFF);
    // Zero alpha on both sides reads as black.
    queue_pixel(make_pixel(8'd40, 8'd0, FULL, 8'd0, 8'd9, 8'd200, 8'd1, 8'd0), 0);
    // Color above alpha clips to 255 once straightened.
    queue_pixel(make_pixel(8'd200, 8'd101, 8'd50, 8'd100, 8'd10, 8'd250, 8'd0, 8'd20), 0);
    queue_pixel(make_pixel(8'd64, 8'd32, 8'd128, 8'd128, 8'd100, 8'd200, 8'd20, 8'd200), 0);
    queue_pixel(make_pixel(FULL, 8'd0, FULL, FULL, 8'd0, FULL, 8'd0, FULL), 0);
    queue_mode(MODE_UNUSED_LO);
    queue_pixel(make_pixel(FULL, FULL, FULL, FULL, FULL, FULL, FULL, FULL), 0);
    queue_mode(MODE_UNUSED_HI);
    queue_pixel(make_pixel(FULL, FULL, FULL, FULL, FULL, FULL, FULL, FULL), 0);

    // Random part: chunks at one mode each, alternating back-to-back
    // traffic with gappy traffic. One chunk stops halfway until the
    // pipeline is empty before resuming.
    random_sent = 0;
    chunk = 0;
    while (random_sent < RANDOM_PIXELS) begin
      queue_mode((chunk == 1) ? MODE_UNUSED_HI : (chunk == 2) ? MODE_OVER : pick_mode());
      chunk_len = $urandom_range(20, 80);
      no_idle   = (chunk % 2) == 0;
      for (k = 0; k < chunk_len; k++) begin
        if ((chunk == 3 && k == chunk_len / 2) || $urandom_range(0, 199) == 0)
          queue_drain();
        queue_pixel(rand_pixel(), no_idle ? 0 : pick_gap());
        random_sent++;
      end
      chunk++;
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pixel_jobs.size() != 0 || start || cfg_valid || predicted_rgba.size() != 0)
      @(posedge clk);
    // Let any stray strobe show up.
    repeat (LATENCY + 4) @(posedge clk);

    if (mismatches == 0 && predicted_rgba.size() == 0) begin
      $display("PASS premultiplied_pixel_compositor_unit");
    end else begin
      $display("FAIL premultiplied_pixel_compositor_unit");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/ppc_pkg.sv
design/ppc_unpremul.sv
design/ppc_blend.sv
design/ppc_lane.sv
design/premultiplied_pixel_compositor_unit.sv
test/testbench.sv
